### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/am6502_pkg.sv
// types and codes of the 6502 address mode unit
`default_nettype none

package am6502_pkg;

    // addressing mode codes
    localparam logic [3:0] AM_IMP = 4'd0;
    localparam logic [3:0] AM_IMM = 4'd1;
    localparam logic [3:0] AM_ZP0 = 4'd2;
    localparam logic [3:0] AM_ZPX = 4'd3;
    localparam logic [3:0] AM_ZPY = 4'd4;
    localparam logic [3:0] AM_REL = 4'd5;
    localparam logic [3:0] AM_ABS = 4'd6;
    localparam logic [3:0] AM_ABX = 4'd7;
    localparam logic [3:0] AM_ABY = 4'd8;
    localparam logic [3:0] AM_IND = 4'd9;
    localparam logic [3:0] AM_IZX = 4'd10;
    localparam logic [3:0] AM_IZY = 4'd11;

    // input beat selector
    localparam logic BEAT_START = 1'b0;
    localparam logic BEAT_RESP  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  read_data;
        logic [7:0]  acc_value;
        logic [7:0]  y_reg;
        logic [7:0]  x_reg;
        logic [15:0] pc_in;
        logic [3:0]  addr_mode;
    } t_in_data;

    typedef struct packed {
        logic [5:0]  pad;
        logic        page_crossed;
        logic [15:0] new_pc;
        logic        implied_valid;
        logic [7:0]  implied_value;
        logic [15:0] relative_offset;
        logic [15:0] effective_addr;
        logic [15:0] read_addr;
    } t_out_data;

endpackage

`default_nettype wire

### rtl/core/cpu_6502_address_mode_unit.sv
// effective-address sequencer for the 6502 addressing modes
//
// usage:
//  - slave stream carries start beats (tuser 0: mode, pc, x, y, accumulator)
//    and read response beats (tuser 1: the byte for the last request)
//  - master stream returns one beat per accepted input beat, tuser giving
//    the kind: read request, address done or unexpected response
//  - a start beat for an indexed or indirect mode is answered by a read
//    request; the user feeds back the byte as a response beat, and so on
//    until the done beat (up to four requests for the indirect modes)
//  - every result beat is registered and appears in the cycle after its input beat
//  - throughput: one input beat per cycle, limited only by the single
//    output register; a response may follow its request in the next cycle
//  - stall: while the output register is full and m_axis_tready is low,
//    s_axis_tready drops and the unit holds its state
//  - reset (i_rst_n low, synchronous) returns the sequencer to idle and
//    empties the output register
//  - a response beat while idle gives an error beat; a start beat while
//    busy drops the computation in progress
`default_nettype none

module cpu_6502_address_mode_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // addr_mode[3:0], pc_in[19:4], x_reg[27:20], y_reg[35:28],
    // acc_value[43:36], read_data[51:44], zero[55:52]
    input  wire logic [am6502_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // mode[0]: 0 start, 1 read response
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_addr[15:0], effective_addr[31:16], relative_offset[47:32],
    // implied_value[55:48], implied_valid[56], new_pc[72:57],
    // page_crossed[73], zero[79:74]
    output logic [am6502_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind[1:0]: 0 read request, 1 done, 2 error
    output logic [1:0]       m_axis_tuser
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OP1,
        PH_OP2,
        PH_PLO,
        PH_PHI
    } t_phase;

    t_phase r_phase, n_phase;
    logic [3:0]  r_held_mode, n_held_mode;
    logic [15:0] r_held_pc, n_held_pc;
    logic [7:0]  r_held_x, n_held_x;
    logic [7:0]  r_held_y, n_held_y;
    logic [7:0]  r_first_byte, n_first_byte;
    logic [7:0]  r_second_byte, n_second_byte;
    logic [7:0]  r_pointer_low, n_pointer_low;

    logic                  r_m_valid;
    am6502_pkg::t_out_data r_m_data, n_m_data;
    logic [1:0]            r_m_kind, n_m_kind;

    am6502_pkg::t_in_data in_d;
    logic                 s_fire;
    logic [7:0]           d;
    logic [15:0]          abs_addr;
    logic [15:0]          ptr_addr;
    logic [15:0]          idx_sum;
    logic [7:0]           idx_val;

    assign in_d          = s_axis_tdata;
    assign d             = in_d.read_data;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // operand or pointer word formed from the byte just returned
    assign abs_addr = {d, r_first_byte};
    assign ptr_addr = {d, r_pointer_low};

    // one shared index adder: abx/aby on the operand word, izy on the pointer
    always_comb begin
        if (r_phase == PH_PHI) begin
            idx_val = r_held_y;
            idx_sum = ptr_addr + {8'h00, r_held_y};
        end else begin
            idx_val = (r_held_mode == am6502_pkg::AM_ABX) ? r_held_x : r_held_y;
            idx_sum = abs_addr + {8'h00, idx_val};
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_held_mode   = r_held_mode;
        n_held_pc     = r_held_pc;
        n_held_x      = r_held_x;
        n_held_y      = r_held_y;
        n_first_byte  = r_first_byte;
        n_second_byte = r_second_byte;
        n_pointer_low = r_pointer_low;
        n_m_data      = '0;
        n_m_kind      = am6502_pkg::KIND_DONE;

        if (s_axis_tuser == am6502_pkg::BEAT_START) begin
            n_held_mode = in_d.addr_mode;
            n_held_pc   = in_d.pc_in;
            n_held_x    = in_d.x_reg;
            n_held_y    = in_d.y_reg;
            n_phase     = PH_IDLE;
            if (in_d.addr_mode == am6502_pkg::AM_IMM) begin
                n_m_data.effective_addr = in_d.pc_in;
                n_m_data.new_pc         = in_d.pc_in + 16'd1;
            end else if (in_d.addr_mode == am6502_pkg::AM_IMP
                         || in_d.addr_mode > am6502_pkg::AM_IZY) begin
                // implied, and the unused codes treated as implied
                n_m_data.new_pc        = in_d.pc_in;
                n_m_data.implied_value = in_d.acc_value;
                n_m_data.implied_valid = 1'b1;
            end else begin
                n_phase            = PH_OP1;
                n_m_kind           = am6502_pkg::KIND_REQ;
                n_m_data.read_addr = in_d.pc_in;
            end
        end else begin
            unique case (r_phase)
                PH_OP1: begin
                    n_first_byte = d;
                    n_phase      = PH_IDLE;
                    n_m_data.new_pc = r_held_pc + 16'd1;
                    unique case (r_held_mode)
                        am6502_pkg::AM_ZP0: begin
                            n_m_data.effective_addr = {8'h00, d};
                        end
                        am6502_pkg::AM_ZPX: begin
                            n_m_data.effective_addr = {8'h00, d + r_held_x};
                        end
                        am6502_pkg::AM_ZPY: begin
                            n_m_data.effective_addr = {8'h00, d + r_held_y};
                        end
                        am6502_pkg::AM_REL: begin
                            n_m_data.relative_offset = {{8{d[7]}}, d};
                        end
                        am6502_pkg::AM_IZX: begin
                            // pointer fetch wraps in page zero
                            n_phase            = PH_PLO;
                            n_m_kind           = am6502_pkg::KIND_REQ;
                            n_m_data           = '0;
                            n_m_data.read_addr = {8'h00, d + r_held_x};
                        end
                        am6502_pkg::AM_IZY: begin
                            n_phase            = PH_PLO;
                            n_m_kind           = am6502_pkg::KIND_REQ;
                            n_m_data           = '0;
                            n_m_data.read_addr = {8'h00, d};
                        end
                        default: begin
                            // absolute group needs the high operand byte
                            n_phase            = PH_OP2;
                            n_m_kind           = am6502_pkg::KIND_REQ;
                            n_m_data           = '0;
                            n_m_data.read_addr = r_held_pc + 16'd1;
                        end
                    endcase
                end
                PH_OP2: begin
                    n_second_byte = d;
                    if (r_held_mode == am6502_pkg::AM_IND) begin
                        n_phase            = PH_PLO;
                        n_m_kind           = am6502_pkg::KIND_REQ;
                        n_m_data.read_addr = abs_addr;
                    end else begin
                        n_phase         = PH_IDLE;
                        n_m_data.new_pc = r_held_pc + 16'd2;
                        if (r_held_mode == am6502_pkg::AM_ABX
                            || r_held_mode == am6502_pkg::AM_ABY) begin
                            n_m_data.effective_addr = idx_sum;
                            n_m_data.page_crossed   = idx_sum[15:8] != abs_addr[15:8];
                        end else begin
                            n_m_data.effective_addr = abs_addr;
                        end
                    end
                end
                PH_PLO: begin
                    n_pointer_low = d;
                    n_phase       = PH_PHI;
                    n_m_kind      = am6502_pkg::KIND_REQ;
                    if (r_held_mode == am6502_pkg::AM_IND) begin
                        // high byte comes from the same page, as on the real part
                        n_m_data.read_addr = {r_second_byte, r_first_byte + 8'd1};
                    end else if (r_held_mode == am6502_pkg::AM_IZX) begin
                        n_m_data.read_addr = {8'h00, r_first_byte + r_held_x + 8'd1};
                    end else begin
                        n_m_data.read_addr = {8'h00, r_first_byte + 8'd1};
                    end
                end
                PH_PHI: begin
                    n_phase = PH_IDLE;
                    if (r_held_mode == am6502_pkg::AM_IND) begin
                        n_m_data.effective_addr = ptr_addr;
                        n_m_data.new_pc         = r_held_pc + 16'd2;
                    end else if (r_held_mode == am6502_pkg::AM_IZX) begin
                        n_m_data.effective_addr = ptr_addr;
                        n_m_data.new_pc         = r_held_pc + 16'd1;
                    end else begin
                        n_m_data.effective_addr = idx_sum;
                        n_m_data.new_pc         = r_held_pc + 16'd1;
                        n_m_data.page_crossed   = idx_sum[15:8] != ptr_addr[15:8];
                    end
                end
                default: begin
                    // response with nothing outstanding
                    n_phase  = PH_IDLE;
                    n_m_kind = am6502_pkg::KIND_ERR;
                end
            endcase
        end
    end

    // sequencer state, working registers and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_m_valid     <= 1'b0;
            r_held_mode   <= '0;
            r_held_pc     <= '0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_first_byte  <= '0;
            r_second_byte <= '0;
            r_pointer_low <= '0;
            r_m_data      <= '0;
            r_m_kind      <= am6502_pkg::KIND_REQ;
        end else begin
            if (s_fire) begin
                r_phase       <= n_phase;
                r_held_mode   <= n_held_mode;
                r_held_pc     <= n_held_pc;
                r_held_x      <= n_held_x;
                r_held_y      <= n_held_y;
                r_first_byte  <= n_first_byte;
                r_second_byte <= n_second_byte;
                r_pointer_low <= n_pointer_low;
                r_m_data      <= n_m_data;
                r_m_kind      <= n_m_kind;
            end
            if (s_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

    `ASSERT_NEXT(a_idle_resp_err, i_clk, i_rst_n,
        s_fire && s_axis_tuser == am6502_pkg::BEAT_RESP && r_phase == PH_IDLE,
        m_axis_tvalid && m_axis_tuser == am6502_pkg::KIND_ERR,
        "response while idle did not give an error beat")
    `ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n,
        s_fire && n_m_kind != am6502_pkg::KIND_REQ,
        r_phase == PH_IDLE,
        "done or error beat left the sequencer busy")
    `ASSERT_IMPL(a_phi_mode, i_clk, i_rst_n,
        r_phase == PH_PHI,
        r_held_mode == am6502_pkg::AM_IND || r_held_mode == am6502_pkg::AM_IZX
            || r_held_mode == am6502_pkg::AM_IZY,
        "pointer fetch in a mode without a pointer")
    `ASSERT_IMPL(a_implied_done, i_clk, i_rst_n,
        m_axis_tvalid && r_m_data.implied_valid,
        m_axis_tuser == am6502_pkg::KIND_DONE && r_m_data.effective_addr == 16'h0000,
        "implied value flagged on a beat that is not an implied done")

endmodule

`default_nettype wire
